>>> rtl/tfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfe_pkg;

  // Field widths
  localparam int unsigned IdW      = 16;
  localparam int unsigned ReadingW = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 4;

  // Frame geometry
  localparam int unsigned FrameLen = 8;
  localparam int unsigned IdxW     = $clog2(FrameLen);
  localparam int unsigned PsumW    = ByteW + 1;
  localparam int unsigned SumW     = ByteW + 3;
  localparam int unsigned NumPsum  = FrameLen / 2;

  // Line coding bytes
  localparam logic [ByteW-1:0] FlagByte = 8'h7E;
  localparam logic [ByteW-1:0] EscByte  = 8'h7D;
  localparam logic [ByteW-1:0] EscFlag  = 8'h5E;
  localparam logic [ByteW-1:0] EscEsc   = 8'h5D;

  // Register reset values
  localparam logic [ByteW-1:0] DataHeaderRst    = 8'h10;
  localparam logic [ByteW-1:0] DiscardHeaderRst = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    RegDataHeader    = 4'd0,
    RegDiscardHeader = 4'd1
  } cfg_reg_e;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t [FrameLen-1:0] frame_t;

  // Frame bytes without checksum, plus pairwise sums
  typedef struct packed {
    frame_t                   bytes;
    logic [NumPsum-1:0][PsumW-1:0] psum;
  } s1_t;

  // Complete frame and per-byte escape flags
  typedef struct packed {
    frame_t              bytes;
    logic [FrameLen-1:0] esc;
  } s2_t;

endpackage

`default_nettype wire

>>> rtl/tfe_intf.sv
`timescale 1ns / 1ps
`default_nettype none

// Sensor reading channel
interface tfe_sens_if;
  logic                          valid;
  logic                          ready;
  logic [tfe_pkg::IdW-1:0]       sensor_id;
  logic [tfe_pkg::ReadingW-1:0]  reading;

  modport source (output valid, sensor_id, reading, input ready);
  modport sink   (input valid, sensor_id, reading, output ready);
endinterface

// Line byte channel
interface tfe_line_if;
  logic                       valid;
  logic                       ready;
  logic [tfe_pkg::ByteW-1:0]  line_byte;
  logic                       last_byte;

  modport source (output valid, line_byte, last_byte, input ready);
  modport sink   (input valid, line_byte, last_byte, output ready);
endinterface

// Register write channel
interface tfe_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tfe_pkg::CfgIdxW-1:0]  reg_index;
  logic [tfe_pkg::ByteW-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/tfe_frame_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module tfe_frame_stage (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tfe_pkg::IdW-1:0]       sensor_id_i,
  input  wire logic [tfe_pkg::ReadingW-1:0]  reading_i,
  input  wire logic [tfe_pkg::ByteW-1:0]     data_header_i,
  input  wire logic [tfe_pkg::ByteW-1:0]     discard_header_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output tfe_pkg::s1_t                       out_o
);
  import tfe_pkg::*;

  logic   valid_q, valid_d;
  logic   accept;
  logic   is_data;
  frame_t bytes;
  s1_t    data_d, data_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_data    = |sensor_id_i;

  // Lay out the frame: header, id and value little-endian, or zeros on discard
  always_comb begin
    bytes    = '0;
    bytes[0] = is_data ? data_header_i : discard_header_i;
    if (is_data) begin
      bytes[1] = sensor_id_i[7:0];
      bytes[2] = sensor_id_i[15:8];
      bytes[3] = reading_i[7:0];
      bytes[4] = reading_i[15:8];
      bytes[5] = reading_i[23:16];
      bytes[6] = reading_i[31:24];
    end
  end

  // Pairwise sums; the checksum slot is still zero
  always_comb begin
    data_d.bytes = bytes;
    for (int unsigned p = 0; p < NumPsum; p++) begin
      data_d.psum[p] = {1'b0, bytes[2*p]} + {1'b0, bytes[2*p+1]};
    end
  end

  assign valid_d = accept ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

>>> rtl/tfe_check_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module tfe_check_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tfe_pkg::s1_t  in_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tfe_pkg::s2_t       out_o
);
  import tfe_pkg::*;

  logic            valid_q, valid_d;
  logic            accept;
  logic [SumW-1:0] sum;
  logic [SumW-1:0] folded;
  s2_t             data_d, data_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Sum the seven bytes and fold the high byte back in
  always_comb begin
    sum = '0;
    for (int unsigned p = 0; p < NumPsum; p++) begin
      sum = sum + {{(SumW-PsumW){1'b0}}, in_i.psum[p]};
    end
    folded = sum + {{(SumW-(SumW-ByteW)){1'b0}}, sum[SumW-1:ByteW]};
  end

  // Insert the checksum and flag every byte that needs an escape
  always_comb begin
    data_d.bytes               = in_i.bytes;
    data_d.bytes[FrameLen-1]   = ~folded[ByteW-1:0];
    for (int unsigned k = 0; k < FrameLen; k++) begin
      data_d.esc[k] = (data_d.bytes[k] == FlagByte) || (data_d.bytes[k] == EscByte);
    end
  end

  assign valid_d = accept ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

>>> rtl/tfe_stuff_serial.sv
`timescale 1ns / 1ps
`default_nettype none

module tfe_stuff_serial (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire tfe_pkg::s2_t               in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [tfe_pkg::ByteW-1:0]       line_byte_o,
  output logic                            last_byte_o
);
  import tfe_pkg::*;

  logic                busy_q, busy_d;
  logic                phase_q, phase_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  s2_t                 frame_q;
  byte_t               cur;
  logic                cur_esc;
  logic                at_end;
  logic                take;
  logic                done;
  logic                load;

  assign cur     = frame_q.bytes[idx_q];
  assign cur_esc = frame_q.esc[idx_q];
  assign at_end  = idx_q == IdxW'(FrameLen - 1);

  // Escape byte first, then the substitute; plain bytes go straight out
  always_comb begin
    if (phase_q) begin
      line_byte_o = (cur == FlagByte) ? EscFlag : EscEsc;
    end else begin
      line_byte_o = cur_esc ? EscByte : cur;
    end
  end

  assign last_byte_o = at_end && (phase_q || !cur_esc);
  assign out_valid_o = busy_q;

  assign take       = busy_q && out_ready_i;
  assign done       = take && last_byte_o;
  assign in_ready_o = !busy_q || done;
  assign load       = in_valid_i && in_ready_o;

  // Advance through the frame one line byte per taken item
  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    if (take) begin
      if (!phase_q && cur_esc) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        idx_d   = idx_q + 1'b1;
      end
      if (done) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= in_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/telemetry_frame_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                        Handshake
// sens_i    in   sensor_id[15:0], reading[31:0]  valid/ready
// line_o    out  line_byte[7:0], last_byte       valid/ready
// cfg_i     in   reg_index[3:0], wdata[7:0]      valid/ready, ready always high
//
// Three register stages: frame layout with pairwise sums, checksum and escape
// flags, then the line serialiser. Each reading passes the frame, check and
// serialiser registers before its first line byte and becomes 8 to 16 line
// bytes, sent one by one by the byte-wide serialiser. Reset clears all valid
// bits and restores both headers. A stall on line_o holds the serialiser and
// backs up the two stages ahead of it, which keep up to two further readings.

module telemetry_frame_encoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tfe_sens_if.sink   sens_i,
  tfe_line_if.source line_o,
  tfe_cfg_if.sink    cfg_i
);
  import tfe_pkg::*;

  byte_t data_header_q;
  byte_t discard_header_q;
  logic  s1_valid, s1_ready;
  s1_t   s1_data;
  logic  s2_valid, s2_ready;
  s2_t   s2_data;

  // Register writes; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_header_q    <= DataHeaderRst;
      discard_header_q <= DiscardHeaderRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        RegDataHeader:    data_header_q    <= cfg_i.wdata;
        RegDiscardHeader: discard_header_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  tfe_frame_stage u_frame (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (sens_i.valid),
    .in_ready_o       (sens_i.ready),
    .sensor_id_i      (sens_i.sensor_id),
    .reading_i        (sens_i.reading),
    .data_header_i    (data_header_q),
    .discard_header_i (discard_header_q),
    .out_valid_o      (s1_valid),
    .out_ready_i      (s1_ready),
    .out_o            (s1_data)
  );

  tfe_check_stage u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_i        (s1_data),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .out_o       (s2_data)
  );

  tfe_stuff_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .in_i        (s2_data),
    .out_valid_o (line_o.valid),
    .out_ready_i (line_o.ready),
    .line_byte_o (line_o.line_byte),
    .last_byte_o (line_o.last_byte)
  );

`ifndef SYNTH
  // No flag byte ever reaches the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_o.valid |-> line_o.line_byte != FlagByte)
    else $error("unescaped flag byte on line");

  // An escape byte is followed at once by its substitute
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_o.valid && line_o.ready && !line_o.last_byte && line_o.line_byte == EscByte)
    |=> (line_o.valid && (line_o.line_byte == EscFlag || line_o.line_byte == EscEsc)))
    else $error("escape byte without substitute");

  // A frame keeps its byte stream going until the marked byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_o.valid && line_o.ready && !line_o.last_byte) |=> line_o.valid)
    else $error("frame cut short");

  // A frame ahead of the serialiser waits until the last byte is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && s2_ready && line_o.valid) |-> (line_o.ready && line_o.last_byte))
    else $error("serialiser reloaded mid-frame");
`endif

endmodule

`default_nettype wire

>>> verif/tfe_frame_checker.sv
`timescale 1ns / 1ps

// Watches the reading, line and register channels of the frame encoder,
// predicts the stuffed line bytes of each accepted reading and compares
// every accepted line item with the oldest prediction.
module tfe_frame_checker
  import tfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sens_valid_i,
  input  logic                sens_ready_i,
  input  logic [IdW-1:0]      sensor_id_i,
  input  logic [ReadingW-1:0] reading_i,
  input  logic                line_valid_i,
  input  logic                line_ready_i,
  input  byte_t               line_byte_i,
  input  logic                last_byte_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  byte_t               cfg_wdata_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    byte_t line_byte;
    logic  last_byte;
  } line_item_t;

  line_item_t  line_q[$];
  byte_t       data_hdr;
  byte_t       discard_hdr;
  int unsigned line_count = 0;

  initial mismatch_count_o = 0;
  initial pending_o = 0;

  // Lay out one frame, add the checksum and queue its stuffed line bytes
  function automatic void queue_frame(input logic [IdW-1:0] id,
                                      input logic [ReadingW-1:0] value);
    frame_t          fr;
    logic [SumW-1:0] sum;
    logic            is_last;
    int unsigned     k;
    if (id != '0) begin
      fr[0] = data_hdr;
      fr[1] = id[7:0];
      fr[2] = id[15:8];
      fr[3] = value[7:0];
      fr[4] = value[15:8];
      fr[5] = value[23:16];
      fr[6] = value[31:24];
    end else begin
      fr[0] = discard_hdr;
      for (k = 1; k < FrameLen - 1; k++) fr[k] = '0;
    end
    // Fold the carry byte back in before taking the complement
    sum = '0;
    for (k = 0; k < FrameLen - 1; k++) sum = sum + fr[k];
    sum = sum + (sum >> ByteW);
    fr[FrameLen-1] = 8'hFF - sum[ByteW-1:0];
    // Escape flag and escape bytes; the marker goes on the final line byte
    for (k = 0; k < FrameLen; k++) begin
      is_last = (k == FrameLen - 1);
      if (fr[k] == FlagByte) begin
        line_q.push_back('{line_byte: EscByte, last_byte: 1'b0});
        line_q.push_back('{line_byte: EscFlag, last_byte: is_last});
      end else if (fr[k] == EscByte) begin
        line_q.push_back('{line_byte: EscByte, last_byte: 1'b0});
        line_q.push_back('{line_byte: EscEsc, last_byte: is_last});
      end else begin
        line_q.push_back('{line_byte: fr[k], last_byte: is_last});
      end
    end
  endfunction

  function automatic void note_mismatch(input string what);
    if (mismatch_count_o < 10) $display("line item %0d: %s", line_count, what);
    mismatch_count_o = mismatch_count_o + 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    line_item_t want;
    if (!rst_ni) begin
      data_hdr    = DataHeaderRst;
      discard_hdr = DiscardHeaderRst;
      line_q.delete();
    end else begin
      // Compare the line item against the oldest prediction
      if (line_valid_i && line_ready_i) begin
        if (line_q.size() == 0) begin
          note_mismatch($sformatf("unexpected, got byte %02h last %0b",
                                  line_byte_i, last_byte_i));
        end else begin
          want = line_q.pop_front();
          if (want.line_byte !== line_byte_i || want.last_byte !== last_byte_i) begin
            note_mismatch($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                    want.line_byte, want.last_byte,
                                    line_byte_i, last_byte_i));
          end
        end
        line_count = line_count + 1;
      end
      // Update the header copies; ignore unknown indexes
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegDataHeader) data_hdr = cfg_wdata_i;
        else if (cfg_index_i == RegDiscardHeader) discard_hdr = cfg_wdata_i;
      end
      if (sens_valid_i && sens_ready_i) queue_frame(sensor_id_i, reading_i);
    end
    pending_o = line_q.size();
  end

endmodule

>>> verif/telemetry_frame_encoder_tb.sv
`timescale 1ns / 1ps

module telemetry_frame_encoder_tb;
  import tfe_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned PhaseItems    = 138;
  localparam int unsigned PausePeriod   = 48;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned send_idle_pct  = 15;
  int unsigned recv_stall_pct = 72;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatch_count;
  int unsigned pending_bytes;

  tfe_sens_if sens_if ();
  tfe_line_if line_if ();
  tfe_cfg_if  cfg_if ();

  telemetry_frame_encoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sens_i (sens_if),
    .line_o (line_if),
    .cfg_i  (cfg_if)
  );

  tfe_frame_checker u_frame_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sens_valid_i     (sens_if.valid),
    .sens_ready_i     (sens_if.ready),
    .sensor_id_i      (sens_if.sensor_id),
    .reading_i        (sens_if.reading),
    .line_valid_i     (line_if.valid),
    .line_ready_i     (line_if.ready),
    .line_byte_i      (line_if.line_byte),
    .last_byte_i      (line_if.last_byte),
    .cfg_valid_i      (cfg_if.valid),
    .cfg_ready_i      (cfg_if.ready),
    .cfg_index_i      (cfg_if.reg_index),
    .cfg_wdata_i      (cfg_if.wdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_bytes)
  );

  always #10 clk_i = ~clk_i;

  // Stall the line output at random
  always @(negedge clk_i) begin
    line_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when no channel has moved an item for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sens_if.valid && sens_if.ready) || (line_if.valid && line_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("telemetry_frame_encoder_tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one reading, idling at random first; leave valid high on return
  task automatic send_reading(input logic [IdW-1:0] id, input logic [ReadingW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      sens_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    sens_if.valid     <= 1'b1;
    sens_if.sensor_id <= id;
    sens_if.reading   <= value;
    do @(posedge clk_i); while (!sens_if.ready);
    @(negedge clk_i);
  endtask

  // Hold off readings until every predicted line byte has come out
  task automatic drain_lines();
    sens_if.valid <= 1'b0;
    while (pending_bytes != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input byte_t value);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
  endtask

  // Write both headers, then a stray write to an unused index
  task automatic configure(input byte_t data_hdr, input byte_t discard_hdr);
    put_reg(RegDataHeader, data_hdr);
    put_reg(RegDiscardHeader, discard_hdr);
    put_reg(CfgIdxW'($urandom_range(2 ** CfgIdxW - 1, RegDiscardHeader + 1)),
            byte_t'($urandom_range(255)));
    cfg_if.valid <= 1'b0;
  endtask

  // Favour the bytes that need escaping and the extremes
  function automatic byte_t pick_byte();
    case ($urandom_range(7))
      0: return FlagByte;
      1: return EscByte;
      2: return 8'h00;
      3: return 8'hFF;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random();
    logic [IdW-1:0]      id;
    logic [ReadingW-1:0] value;
    case ($urandom_range(9))
      0: id = '0;
      1, 2: id = {pick_byte(), pick_byte()};
      default: id = IdW'($urandom);
    endcase
    if ($urandom_range(2) == 0) value = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    else value = $urandom;
    send_reading(id, value);
  endtask

  initial begin
    sens_if.valid     = 1'b0;
    sens_if.sensor_id = '0;
    sens_if.reading   = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.reg_index  = RegDataHeader;
    cfg_if.wdata      = '0;
    line_if.ready     = 1'b0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset headers: extremes, discard frames, escaped bytes, escaped checksums
    send_reading(16'h0001, 32'h0000_0000);
    send_reading(16'hFFFF, 32'hFFFF_FFFF);
    send_reading(16'h0000, 32'h1234_5678);
    send_reading(16'h0000, 32'h0000_0000);
    send_reading(16'h7E7D, 32'h7E7D_7E7D);
    send_reading(16'h0001, 32'h0000_0070);
    send_reading(16'h0001, 32'h0000_0071);
    send_reading(16'h8000, 32'h8000_0000);
    send_reading(16'h00FF, 32'h00FF_00FF);
    drain_lines();

    // Headers that need escaping
    configure(FlagByte, EscByte);
    send_reading(16'h1234, 32'h7D7E_0000);
    send_reading(16'h0000, 32'hFFFF_FFFF);
    send_reading(16'h7D7E, 32'h0000_7E7D);
    drain_lines();

    // Header extremes
    configure(8'hFF, 8'hFF);
    send_reading(16'hFFFF, 32'hFFFF_FFFF);
    send_reading(16'h0000, 32'h0000_0000);
    send_reading(16'h0001, 32'h0000_0000);
    drain_lines();
    configure(8'h00, 8'h00);
    send_reading(16'h0001, 32'h0000_0000);
    send_reading(16'h0000, 32'h0000_0005);
    drain_lines();

    // Random readings in three idling phases, pausing now and then until idle
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 15;
          recv_stall_pct = 72;
        end
        1: begin
          send_idle_pct  = 72;
          recv_stall_pct = 15;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      configure(pick_byte(), pick_byte());
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % PausePeriod == PausePeriod - 1) drain_lines();
        send_random();
      end
      drain_lines();
    end

    repeat (2 * SettleCycles) @(negedge clk_i);
    if (mismatch_count == 0 && pending_bytes == 0) begin
      $display("telemetry_frame_encoder_tb passed");
    end else begin
      $display("telemetry_frame_encoder_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tfe_pkg.sv
rtl/tfe_intf.sv
rtl/tfe_frame_stage.sv
rtl/tfe_check_stage.sv
rtl/tfe_stuff_serial.sv
rtl/telemetry_frame_encoder.sv
verif/tfe_frame_checker.sv
verif/telemetry_frame_encoder_tb.sv
